### rtl/obstacle_box_table_macros.svh
// Assertion macros shared by the obstacle box table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OBSTACLE_BOX_TABLE_MACROS_SVH
`define OBSTACLE_BOX_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obstacle box table check failed");

// Next-cycle implication, checked outside reset.
`define OBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obstacle box table check failed");

`endif

### rtl/obt_pkg.sv
// Shared types and constants of the obstacle box table.
// No dependencies; imported by every module of the block.
package obt_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_LIM,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [18:0]        ext_x;
        logic [18:0]        ext_y;
        logic [18:0]        ext_z;
        logic               is_dynamic;
        logic [15:0]        delta_ms;
    } t_in_item;

    typedef struct packed {
        logic       navigable;
        logic [6:0] removed_count;
        logic [6:0] entry_count;
        logic       dropped;
    } t_out_item;

    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [19:0] cz;
        logic [18:0]        ex;
        logic [18:0]        ey;
        logic [18:0]        ez;
        logic [31:0]        stamp;
    } t_box;

    typedef struct packed {
        logic  valid;
        logic  last;
        t_func func;
    } t_eval_ctl;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
        logic free;
    } t_eval_res;

    localparam int          FLAG_VALID     = 0;
    localparam int          FLAG_DYN       = 1;
    localparam int          REG_LIFETIME   = 0;
    localparam int          REG_SWEEP      = 1;
    localparam int          ADDR_W         = 3;
    localparam logic [2:0]  ADDR_LIFETIME  = 3'(4 * REG_LIFETIME);
    localparam logic [2:0]  ADDR_SWEEP     = 3'(4 * REG_SWEEP);
    localparam logic [31:0] LIFETIME_RESET = 32'd10000;
    localparam logic [15:0] SWEEP_RESET    = 16'd100;

endpackage

### rtl/obt_cfg.sv
// Configuration registers of the obstacle box table behind an APB-style port.
// Depends on obt_pkg.
module obt_cfg
    import obt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       o_lifetime,
    output logic [15:0]       o_sweep_int
);

    logic [31:0] r_lifetime;
    logic [15:0] r_sweep_int;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime  <= LIFETIME_RESET;
            r_sweep_int <= SWEEP_RESET;
        end else if (wr) begin
            if (paddr == ADDR_LIFETIME) begin
                r_lifetime <= pwdata;
            end
            if (paddr == ADDR_SWEEP) begin
                r_sweep_int <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            ADDR_LIFETIME: prdata = r_lifetime;
            ADDR_SWEEP:    prdata = {16'd0, r_sweep_int};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_lifetime  = r_lifetime;
    assign o_sweep_int = r_sweep_int;

endmodule

### rtl/obt_store.sv
// Box storage: a data memory (centre, extents, stamp) and a flags memory.
// Depends on obt_pkg. Both memories have one write and one registered read.
module obt_store
    import obt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_box_we,
    input  logic [IW-1:0] i_box_waddr,
    input  t_box          i_box_wdata,
    input  logic          i_flag_we,
    input  logic [IW-1:0] i_flag_waddr,
    input  logic [1:0]    i_flag_wdata,
    output t_box          o_box,
    output logic [1:0]    o_flags
);

    t_box       mem_box  [DEPTH];
    logic [1:0] mem_flag [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_box_we) begin
            mem_box[i_box_waddr] <= i_box_wdata;
        end
        o_box <= mem_box[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_flag_we) begin
            mem_flag[i_flag_waddr] <= i_flag_wdata;
        end
        o_flags <= mem_flag[i_rd_addr];
    end

endmodule

### rtl/obt_eval.sv
// Per-entry evaluation pipeline: distance, containment and age tests.
// Depends on obt_pkg; fed by the registered read port of obt_store.
module obt_eval
    import obt_pkg::*;
#(
    parameter int IW = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_eval_ctl          i_ctl,
    input  logic [IW-1:0]      i_idx,
    input  t_box               i_box,
    input  logic [1:0]         i_flags,
    input  logic signed [19:0] i_pos_x,
    input  logic signed [19:0] i_pos_y,
    input  logic signed [19:0] i_pos_z,
    input  logic [39:0]        i_lim,
    input  logic [31:0]        i_time,
    input  logic [31:0]        i_lifetime,
    output t_eval_res          o_res,
    output logic [IW-1:0]      o_idx
);

    t_eval_ctl     r0_ctl, ra_ctl, rb_ctl;
    logic [IW-1:0] r0_idx, ra_idx, rb_idx;

    logic [19:0] ra_dx, ra_dy, ra_dz;
    logic [18:0] ra_ex, ra_ey, ra_ez;
    logic        ra_valid, ra_dyn, ra_old;

    logic [39:0] rb_sx, rb_sy, rb_sz;
    logic        rb_inside, rb_valid, rb_dyn, rb_old;

    logic signed [20:0] dx, dy, dz;
    logic [41:0]        d2;
    logic               hit;

    function automatic logic [19:0] abs21(input logic signed [20:0] v);
        logic signed [20:0] m;
        m = v[20] ? -v : v;
        return m[19:0];
    endfunction

    assign dx = 21'(i_pos_x) - 21'(i_box.cx);
    assign dy = 21'(i_pos_y) - 21'(i_box.cy);
    assign dz = 21'(i_pos_z) - 21'(i_box.cz);

    // Control pipe carries a reset; the payload stages do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
            ra_ctl <= '0;
            rb_ctl <= '0;
            o_res  <= '0;
        end else begin
            r0_ctl      <= i_ctl;
            ra_ctl      <= r0_ctl;
            rb_ctl      <= ra_ctl;
            o_res.valid <= rb_ctl.valid;
            o_res.last  <= rb_ctl.last;
            o_res.hit   <= hit;
            o_res.free  <= !rb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_idx   <= i_idx;
        ra_idx   <= r0_idx;
        rb_idx   <= ra_idx;
        o_idx    <= rb_idx;
        ra_dx    <= abs21(dx);
        ra_dy    <= abs21(dy);
        ra_dz    <= abs21(dz);
        ra_ex    <= i_box.ex;
        ra_ey    <= i_box.ey;
        ra_ez    <= i_box.ez;
        ra_valid <= i_flags[FLAG_VALID];
        ra_dyn   <= i_flags[FLAG_DYN];
        ra_old   <= (i_time - i_box.stamp) > i_lifetime;
        rb_sx    <= ra_dx * ra_dx;
        rb_sy    <= ra_dy * ra_dy;
        rb_sz    <= ra_dz * ra_dz;
        rb_inside <= (ra_dx < {1'b0, ra_ex}) && (ra_dy < {1'b0, ra_ey})
                     && (ra_dz < {1'b0, ra_ez});
        rb_valid <= ra_valid;
        rb_dyn   <= ra_dyn;
        rb_old   <= ra_old;
    end

    assign d2 = {2'b0, rb_sx} + {2'b0, rb_sy} + {2'b0, rb_sz};

    always_comb begin
        case (rb_ctl.func)
            FUNC_REMOVE: hit = rb_valid && (d2 < {2'b0, i_lim});
            FUNC_QUERY:  hit = rb_valid && rb_inside;
            FUNC_TICK:   hit = rb_valid && rb_dyn && rb_old;
            default:     hit = 1'b0;
        endcase
    end

endmodule

### rtl/obstacle_box_table.sv
// Top level of the obstacle box table: sequencer, counters and result register.
// Depends on obt_pkg, obt_cfg, obt_store, obt_eval and the assertion macro header.
//
// The block holds up to TABLE_DEPTH axis-aligned boxes and takes one command item
// at a time: an item is accepted when start is high and busy is low, and busy stays
// high until its single result has been shown. The result appears on o_result for
// exactly one cycle with o_strobe high; the receiver cannot stall it, so it must
// capture the result in that cycle. After reset the block first clears the flags
// memory, one entry per cycle, and busy stays high until every entry has been
// cleared; configuration writes are accepted throughout. An add, remove, query or
// sweeping tick walks the whole table through one read port of the box memories
// and a four-stage evaluation pipe. An add to a full table and a tick that does
// not sweep skip the walk and go from ST_LIM straight to ST_DONE. lifetime_ms and
// sweep_interval_ms are written through the APB-style port at byte addresses 0
// and 4; they should be changed only while the block is idle.
module obstacle_box_table
    import obt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_strobe,
    output t_out_item         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    `include "obstacle_box_table_macros.svh"

    localparam int            IW   = $clog2(TABLE_DEPTH);
    localparam int            CW   = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    t_state r_state, n_state;

    t_in_item      r_item;
    logic [IW-1:0] r_cnt;
    logic [CW-1:0] r_held, r_removed;
    logic          r_nav, r_dropped, r_found;
    logic [31:0]   r_time;
    logic [16:0]   r_sweep;
    logic [37:0]   r_esq_x, r_esq_y, r_esq_z;
    logic [39:0]   r_lim;

    logic [31:0] lifetime;
    logic [15:0] sweep_int;

    t_eval_ctl     ctl;
    t_eval_res     res;
    logic [IW-1:0] res_idx;
    t_box          rd_box;
    logic [1:0]    rd_flags;

    logic          box_we, flag_we;
    logic [IW-1:0] flag_waddr;
    logic [1:0]    flag_wdata;
    t_box          box_wdata;
    logic          add_hit, del_hit, accept;
    logic [CW+6:0] held_wide, removed_wide;

    obt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_lifetime  (lifetime),
        .o_sweep_int (sweep_int)
    );

    obt_store #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_addr    (r_cnt),
        .i_box_we     (box_we),
        .i_box_waddr  (res_idx),
        .i_box_wdata  (box_wdata),
        .i_flag_we    (flag_we),
        .i_flag_waddr (flag_waddr),
        .i_flag_wdata (flag_wdata),
        .o_box        (rd_box),
        .o_flags      (rd_flags)
    );

    obt_eval #(
        .IW (IW)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_idx      (r_cnt),
        .i_box      (rd_box),
        .i_flags    (rd_flags),
        .i_pos_x    (r_item.pos_x),
        .i_pos_y    (r_item.pos_y),
        .i_pos_z    (r_item.pos_z),
        .i_lim      (r_lim),
        .i_time     (r_time),
        .i_lifetime (lifetime),
        .o_res      (res),
        .o_idx      (res_idx)
    );

    // The pipe only ever writes back the entry it has just finished with, and
    // reads run strictly ahead in ascending order, so read and write never meet.
    assign add_hit = res.valid && (r_item.func == FUNC_ADD) && res.free && !r_found;
    assign del_hit = res.valid && res.hit
                     && (r_item.func == FUNC_REMOVE || r_item.func == FUNC_TICK);

    assign box_wdata = '{cx: r_item.pos_x, cy: r_item.pos_y, cz: r_item.pos_z,
                         ex: r_item.ext_x, ey: r_item.ext_y, ez: r_item.ext_z,
                         stamp: r_time};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_cnt == LAST) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_PREP;
            ST_PREP:  n_state = ST_LIM;
            ST_LIM: begin
                case (r_item.func)
                    FUNC_ADD:  n_state = (r_held >= CW'(TABLE_DEPTH)) ? ST_DONE : ST_SCAN;
                    FUNC_TICK: n_state = (r_sweep >= {1'b0, sweep_int}) ? ST_SCAN : ST_DONE;
                    default:   n_state = ST_SCAN;
                endcase
            end
            ST_SCAN:  if (r_cnt == LAST) n_state = ST_DRAIN;
            ST_DRAIN: if (res.valid && res.last) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory controls decoded from the state.
    always_comb begin
        busy       = (r_state != ST_IDLE);
        o_strobe   = (r_state == ST_DONE);
        ctl.valid  = (r_state == ST_SCAN);
        ctl.last   = (r_cnt == LAST);
        ctl.func   = r_item.func;
        box_we     = add_hit;
        flag_we    = (r_state == ST_CLEAR) || add_hit || del_hit;
        flag_waddr = (r_state == ST_CLEAR) ? r_cnt : res_idx;
        flag_wdata = add_hit ? {r_item.is_dynamic, 1'b1} : 2'b00;
    end

    assign accept = (r_state == ST_IDLE) && start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_held    <= '0;
            r_removed <= '0;
            r_nav     <= 1'b1;
            r_dropped <= 1'b0;
            r_found   <= 1'b0;
            r_time    <= '0;
            r_sweep   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_removed <= '0;
                r_nav     <= 1'b1;
                r_dropped <= 1'b0;
                r_found   <= 1'b0;
            end
            if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + IW'(1);
            end
            if (r_state == ST_PREP && r_item.func == FUNC_TICK) begin
                r_time  <= r_time + 32'(r_item.delta_ms);
                r_sweep <= r_sweep + 17'(r_item.delta_ms);
            end
            if (r_state == ST_LIM) begin
                if (r_item.func == FUNC_ADD && r_held >= CW'(TABLE_DEPTH)) begin
                    r_dropped <= 1'b1;
                end
                if (r_item.func == FUNC_TICK && r_sweep >= {1'b0, sweep_int}) begin
                    r_sweep <= '0;
                end
            end
            if (add_hit) begin
                r_found <= 1'b1;
                r_held  <= r_held + CW'(1);
            end
            if (del_hit) begin
                r_held    <= r_held - CW'(1);
                r_removed <= r_removed + CW'(1);
            end
            if (res.valid && res.hit && r_item.func == FUNC_QUERY) begin
                r_nav <= 1'b0;
            end
        end
    end

    // Payload registers: the item and the squared removal radius.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_esq_x <= r_item.ext_x * r_item.ext_x;
        r_esq_y <= r_item.ext_y * r_item.ext_y;
        r_esq_z <= r_item.ext_z * r_item.ext_z;
        if (r_state == ST_LIM) begin
            r_lim <= {2'b0, r_esq_x} + {2'b0, r_esq_y} + {2'b0, r_esq_z};
        end
    end

    assign held_wide    = {7'd0, r_held};
    assign removed_wide = {7'd0, r_removed};

    assign o_result = '{navigable: r_nav, removed_count: removed_wide[6:0],
                        entry_count: held_wide[6:0], dropped: r_dropped};

    `OBT_ASSERT_NOW(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= CW'(TABLE_DEPTH))
    `OBT_ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, o_strobe, !busy)
    `OBT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy && !o_strobe)
    `OBT_ASSERT_NOW(a_drop_when_full, i_clk, i_rst_n, o_strobe && r_dropped, r_held == CW'(TABLE_DEPTH))
    `OBT_ASSERT_NOW(a_pipe_in_walk, i_clk, i_rst_n, res.valid, r_state == ST_SCAN || r_state == ST_DRAIN)

endmodule

### dv/tb_top.sv
// Self-checking testbench of the obstacle box table: directed and random command items.
// Depends on obt_pkg and the obstacle_box_table RTL; predicts each result internally.
module tb_top
    import obt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_item          i_item = '0;
    logic              o_strobe;
    t_out_item         o_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    obstacle_box_table #(.TABLE_DEPTH(DEPTH)) uut (.*);

    always #5 i_clk = ~i_clk;

    // The table model: one entry per slot, mirroring what the block should hold.
    logic signed [19:0] tbl_cx [DEPTH], tbl_cy [DEPTH], tbl_cz [DEPTH];
    logic [18:0]        tbl_ex [DEPTH], tbl_ey [DEPTH], tbl_ez [DEPTH];
    logic [31:0]        tbl_stamp [DEPTH];
    logic               tbl_valid [DEPTH], tbl_dyn [DEPTH];
    logic [31:0]        now_ms, sweep_acc;
    int                 held;
    logic [31:0]        lifetime_reg;
    logic [15:0]        sweep_reg;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int        fail_count;
    int        accepted_count;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    logic      hold_off;

    function automatic longint unsigned dist_abs(logic signed [19:0] a, logic signed [19:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? longint'(-d) : longint'(d);
    endfunction

    // Applies one command item to the table model and returns the result it should give.
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item r;
        longint unsigned lim, d2, dx, dy, dz;
        int removed;
        r = '0;
        r.navigable = 1'b1;
        removed = 0;
        case (it.func)
            FUNC_ADD: begin
                if (held >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!tbl_valid[i]) begin
                            tbl_cx[i] = it.pos_x; tbl_cy[i] = it.pos_y; tbl_cz[i] = it.pos_z;
                            tbl_ex[i] = it.ext_x; tbl_ey[i] = it.ext_y; tbl_ez[i] = it.ext_z;
                            tbl_stamp[i] = now_ms;
                            tbl_valid[i] = 1'b1;
                            tbl_dyn[i] = it.is_dynamic;
                            held++;
                            break;
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                lim = longint'(it.ext_x) * it.ext_x + longint'(it.ext_y) * it.ext_y
                    + longint'(it.ext_z) * it.ext_z;
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        dx = dist_abs(tbl_cx[i], it.pos_x);
                        dy = dist_abs(tbl_cy[i], it.pos_y);
                        dz = dist_abs(tbl_cz[i], it.pos_z);
                        d2 = dx * dx + dy * dy + dz * dz;
                        if (d2 < lim) begin
                            tbl_valid[i] = 1'b0;
                            tbl_dyn[i] = 1'b0;
                            held--;
                            removed++;
                        end
                    end
                end
            end
            FUNC_QUERY: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i] && dist_abs(it.pos_x, tbl_cx[i]) < tbl_ex[i]
                            && dist_abs(it.pos_y, tbl_cy[i]) < tbl_ey[i]
                            && dist_abs(it.pos_z, tbl_cz[i]) < tbl_ez[i]) begin
                        r.navigable = 1'b0;
                        break;
                    end
                end
            end
            default: begin
                now_ms = now_ms + it.delta_ms;
                sweep_acc = sweep_acc + it.delta_ms;
                if (sweep_acc >= {16'd0, sweep_reg}) begin
                    sweep_acc = '0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (tbl_valid[i] && tbl_dyn[i] && (now_ms - tbl_stamp[i]) > lifetime_reg) begin
                            tbl_valid[i] = 1'b0;
                            tbl_dyn[i] = 1'b0;
                            held--;
                            removed++;
                        end
                    end
                end
            end
        endcase
        r.removed_count = 7'(removed);
        r.entry_count = 7'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Driver: bursts of items separated by random gaps, fed from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (start && !busy) begin
            // The item on the port has been taken; predict its result now.
            expected_results.push_back(apply_command(i_item));
            accepted_count++;
            start <= 1'b0;
        end else if (!start && !hold_off && pending_items.size() > 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                i_item <= pending_items.pop_front();
                start <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, entry_count", o_result.entry_count, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.navigable !== want.navigable)
                    report_mismatch("navigable", o_result.navigable, want.navigable);
                if (o_result.removed_count !== want.removed_count)
                    report_mismatch("removed_count", o_result.removed_count, want.removed_count);
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_result.entry_count, want.entry_count);
                if (o_result.dropped !== want.dropped)
                    report_mismatch("dropped", o_result.dropped, want.dropped);
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result is accepted.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("obstacle_box_table: mismatch");
            $finish;
        end
    end

    // Generic random item of the given operation, over the full field ranges.
    function automatic t_in_item rand_item(t_func f);
        t_in_item it;
        it = '0;
        it.func = f;
        it.pos_x = 20'($urandom); it.pos_y = 20'($urandom); it.pos_z = 20'($urandom);
        it.ext_x = 19'($urandom); it.ext_y = 19'($urandom); it.ext_z = 19'($urandom);
        it.is_dynamic = 1'($urandom);
        it.delta_ms = 16'($urandom);
        return it;
    endfunction

    // Item near a small cluster so that hits, removals and misses all happen often.
    function automatic t_in_item near_item(t_func f);
        t_in_item it;
        it = rand_item(f);
        it.pos_x = 20'(int'($urandom_range(0, 400)) - 200);
        it.pos_y = 20'(int'($urandom_range(0, 400)) - 200);
        it.pos_z = 20'(int'($urandom_range(0, 400)) - 200);
        it.ext_x = 19'($urandom_range(0, 150));
        it.ext_y = 19'($urandom_range(0, 150));
        it.ext_z = 19'($urandom_range(0, 150));
        it.delta_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        return it;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_LIFETIME) lifetime_reg = data;
        else sweep_reg = data[15:0];
    endtask

    // Lets the block finish everything queued and stops the driver before a write.
    task automatic wait_idle();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        hold_off = 1'b1;
        repeat (DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) pending_items.push_back(rand_item(t_func'($urandom_range(0, 3))));
            else if (pick < 34) pending_items.push_back(near_item(FUNC_ADD));
            else if (pick < 46) pending_items.push_back(near_item(FUNC_REMOVE));
            else if (pick < 72) pending_items.push_back(near_item(FUNC_QUERY));
            else pending_items.push_back(near_item(FUNC_TICK));
        end
        hold_off = 1'b0;
    endtask

    initial begin
        t_in_item it;
        fail_count = 0;
        accepted_count = 0;
        idle_cycles = 0;
        hold_off = 1'b1;
        now_ms = '0;
        sweep_acc = '0;
        held = 0;
        lifetime_reg = LIFETIME_RESET;
        sweep_reg = SWEEP_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_dyn[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every field, each operation and the special cases.
        it = '0; it.func = FUNC_QUERY; pending_items.push_back(it);
        it = '0; it.func = FUNC_ADD; it.pos_x = 20'sh80000; it.pos_y = 20'sh7FFFF;
        it.pos_z = 20'sh80000; it.ext_x = '1; it.ext_y = '1; it.ext_z = '1;
        it.is_dynamic = 1'b1; pending_items.push_back(it);
        it.func = FUNC_QUERY; it.pos_x = 20'sh7FFFF; pending_items.push_back(it);
        it.pos_x = 20'sh80001; pending_items.push_back(it);
        it = '0; it.func = FUNC_ADD; it.ext_y = 19'd5; it.ext_z = 19'd5;
        pending_items.push_back(it);      // zero x extent: contains nothing
        it.func = FUNC_QUERY; pending_items.push_back(it);
        it = '0; it.func = FUNC_REMOVE; pending_items.push_back(it);   // zero vector
        it = '0; it.func = FUNC_TICK; it.delta_ms = 16'hFFFF; pending_items.push_back(it);
        it.delta_ms = 16'd0; pending_items.push_back(it);
        it = '0; it.func = FUNC_REMOVE; it.pos_x = 20'sh7FFFF; it.ext_x = '1;
        it.ext_y = '1; it.ext_z = '1; pending_items.push_back(it);
        hold_off = 1'b0;
        wait_idle();

        // Fill the table past full so that drops are seen, then clear it by removal.
        write_reg(ADDR_LIFETIME, 32'd0);
        write_reg(ADDR_SWEEP, 16'd0);
        for (int i = 0; i < DEPTH + 3; i++) pending_items.push_back(near_item(FUNC_ADD));
        it = '0; it.func = FUNC_TICK; it.delta_ms = 16'd1; pending_items.push_back(it);
        it = '0; it.func = FUNC_REMOVE; it.ext_x = '1; it.ext_y = '1; it.ext_z = '1;
        pending_items.push_back(it);
        hold_off = 1'b0;
        wait_idle();

        // Random phases under several register settings, extremes included.
        run_phase(300);
        wait_idle();
        write_reg(ADDR_LIFETIME, 32'hFFFF_FFFF);
        write_reg(ADDR_SWEEP, 16'hFFFF);
        run_phase(250);
        wait_idle();
        write_reg(ADDR_LIFETIME, 32'd150);
        write_reg(ADDR_SWEEP, 16'd50);
        run_phase(350);
        wait_idle();
        write_reg(ADDR_LIFETIME, 32'($urandom_range(0, 2000)));
        write_reg(ADDR_SWEEP, 16'($urandom_range(0, 400)));
        run_phase(300);
        wait_idle();
        write_reg(ADDR_LIFETIME, 32'd10);
        write_reg(ADDR_SWEEP, 16'd0);
        run_phase(180);
        wait_idle();

        if (fail_count == 0) begin
            $display("obstacle_box_table: match");
        end else begin
            $display("obstacle_box_table: mismatch");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/obt_pkg.sv
rtl/obt_cfg.sv
rtl/obt_store.sv
rtl/obt_eval.sv
rtl/obstacle_box_table.sv
dv/tb_top.sv
